FILE: rtl/ttv_pkg.sv
`timescale 1ns / 1ps
package ttv_pkg;

   localparam int DeltaWidth = 17;
   localparam int ProdWidth  = 34;
   localparam int WideWidth  = 35;
   localparam int QuotWidth  = 32;
   localparam int GainShift  = 18;
   localparam int RemWidth   = WideWidth + GainShift;
   localparam int CmpWidth   = WideWidth + QuotWidth - 1;
   localparam int ReqWidth   = 240;
   localparam int RspWidth   = 96;

   localparam logic [QuotWidth-1:0] SatMax = 32'h7FFF_FFFF;
   localparam logic [QuotWidth-1:0] SatMin = 32'h8000_0000;

   // One component travelling down the divider row
   typedef struct packed {
      logic                   valid;
      logic                   degen;
      logic                   neg;
      logic                   ovf;
      logic [WideWidth-1:0]   dvsr;
      logic [RemWidth-1:0]    rem;
      logic [QuotWidth-1:0]   quot;
   } lane_type;

   function automatic logic signed [DeltaWidth-1:0] sx16(input logic [15:0] a);
      return $signed({a[15], a});
   endfunction

endpackage

FILE: rtl/ttv_front.sv
`timescale 1ns / 1ps
module ttv_front
   import ttv_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [ReqWidth-1:0] in_data,
   output lane_type [2:0]      lanes
);

   logic [47:0] va, vb, vc;
   logic [31:0] ua, ub, uc;
   assign va = in_data[47:0];
   assign vb = in_data[95:48];
   assign vc = in_data[143:96];
   assign ua = in_data[175:144];
   assign ub = in_data[207:176];
   assign uc = in_data[239:208];

   // stage 1: deltas
   logic                          s1_valid_ff;
   logic signed [DeltaWidth-1:0]  du1_ff, dv1_ff, du2_ff, dv2_ff;
   logic signed [DeltaWidth-1:0]  e1_ff [3];
   logic signed [DeltaWidth-1:0]  e2_ff [3];
   // stage 2: products
   logic                          s2_valid_ff;
   logic signed [ProdWidth-1:0]   pa_ff, pb_ff;
   logic signed [ProdWidth-1:0]   pn1_ff [3];
   logic signed [ProdWidth-1:0]   pn2_ff [3];
   // stage 3: determinant and numerators
   logic                          s3_valid_ff;
   logic signed [WideWidth-1:0]   det_ff;
   logic signed [WideWidth-1:0]   num_ff [3];
   // stage 4: magnitudes and overflow test
   lane_type [2:0]                lane_ff;
   lane_type [2:0]                lane_in;
   logic [WideWidth-1:0]          dmag;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         du1_ff <= sx16(ub[15:0])  - sx16(ua[15:0]);
         dv1_ff <= sx16(ub[31:16]) - sx16(ua[31:16]);
         du2_ff <= sx16(uc[15:0])  - sx16(ua[15:0]);
         dv2_ff <= sx16(uc[31:16]) - sx16(ua[31:16]);
         for (int k = 0; k < 3; k++) begin
            e1_ff[k] <= sx16(vb[16*k +: 16]) - sx16(va[16*k +: 16]);
            e2_ff[k] <= sx16(vc[16*k +: 16]) - sx16(va[16*k +: 16]);
         end
         pa_ff <= du1_ff * dv2_ff;
         pb_ff <= du2_ff * dv1_ff;
         for (int k = 0; k < 3; k++) begin
            pn1_ff[k] <= dv2_ff * e1_ff[k];
            pn2_ff[k] <= dv1_ff * e2_ff[k];
         end
         det_ff <= WideWidth'(pa_ff) - WideWidth'(pb_ff);
         for (int k = 0; k < 3; k++) begin
            num_ff[k] <= WideWidth'(pn1_ff[k]) - WideWidth'(pn2_ff[k]);
         end
      end
   end

   always_comb begin
      logic [WideWidth-1:0] nmag;
      dmag = det_ff[WideWidth-1] ? WideWidth'(-det_ff) : WideWidth'(det_ff);
      for (int k = 0; k < 3; k++) begin
         nmag = num_ff[k][WideWidth-1] ? WideWidth'(-num_ff[k]) : WideWidth'(num_ff[k]);
         lane_in[k].valid = s3_valid_ff;
         lane_in[k].degen = (det_ff == '0);
         lane_in[k].neg   = num_ff[k][WideWidth-1] ^ det_ff[WideWidth-1];
         // quotient reaches 2^32 when |N| >= |D| * 2^14
         lane_in[k].ovf   = ({14'b0, nmag} >= {dmag, 14'b0});
         lane_in[k].dvsr  = dmag;
         lane_in[k].rem   = {nmag, {GainShift{1'b0}}};
         lane_in[k].quot  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 3; k++) lane_ff[k].valid <= 1'b0;
      end else if (en) begin
         lane_ff <= lane_in;
      end
   end

   assign lanes = lane_ff;

endmodule

FILE: rtl/ttv_div_cell.sv
`timescale 1ns / 1ps
module ttv_div_cell
   import ttv_pkg::*;
#(
   parameter int BIT = 0
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     en,
   input  lane_type lane_i,
   output lane_type lane_o
);

   lane_type             lane_ff;
   lane_type             lane_in;
   logic [CmpWidth-1:0]  rem_x;
   logic [CmpWidth-1:0]  dvsr_x;

   // restoring step: try the divisor shifted to this quotient bit
   always_comb begin
      rem_x   = CmpWidth'(lane_i.rem);
      dvsr_x  = CmpWidth'(lane_i.dvsr) << BIT;
      lane_in = lane_i;
      if (rem_x >= dvsr_x) begin
         lane_in.rem       = lane_i.rem - dvsr_x[RemWidth-1:0];
         lane_in.quot[BIT] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ff.valid <= 1'b0;
      end else if (en) begin
         lane_ff <= lane_in;
      end
   end

   assign lane_o = lane_ff;

endmodule

FILE: rtl/triangle_tangent_vector.sv
`timescale 1ns / 1ps
// Per-triangle tangent vector.
// Input channel req_*: one item per triangle, three Q4.12 vertex positions and
// three Q2.14 texture coordinates. Result channel rsp_*: one item per triangle,
// the tangent as three saturated Q16.16 components, plus a degenerate flag in
// rsp_tuser that is set (with zero components) when the UV determinant is zero.
// Datapath: four front stages form deltas, products, determinant and numerators,
// and magnitudes, then a row of 32 divider cells per component each settles one
// quotient bit and hands the partial remainder on, then an output register
// applies sign and saturation.
// Throughput: one triangle per cycle while the row is not stalled.
// Reset clears every valid flag; no item is in flight afterwards.
// Stall: while a result waits and rsp_tready is low the whole row holds and
// req_tready drops; the row advances again in the cycle the result is taken.
module triangle_tangent_vector
   import ttv_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   // vertex_a, vertex_b, vertex_c, uv_a, uv_b, uv_c
   input  logic [ReqWidth-1:0] req_tdata,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // tangent_x, tangent_y, tangent_z
   output logic [RspWidth-1:0] rsp_tdata,
   // degenerate
   output logic                rsp_tuser
);

   logic                 en;
   lane_type [2:0]       chain [QuotWidth+1];
   logic                 rsp_tvalid_ff, rsp_tvalid_in;
   logic [RspWidth-1:0]  rsp_tdata_ff, rsp_tdata_in;
   logic                 rsp_tuser_ff, rsp_tuser_in;

   // advance while the output register is empty or being drained
   assign en         = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = en;

   ttv_front u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_tvalid),
      .in_data  (req_tdata),
      .lanes    (chain[0])
   );

   // cell j settles quotient bit 31-j for each component
   for (genvar j = 0; j < QuotWidth; j++) begin : g_cell
      for (genvar k = 0; k < 3; k++) begin : g_lane
         ttv_div_cell #(.BIT(QuotWidth - 1 - j)) u_cell (
            .clock  (clock),
            .reset  (reset),
            .en     (en),
            .lane_i (chain[j][k]),
            .lane_o (chain[j+1][k])
         );
      end
   end

   // sign and saturate the finished quotients
   always_comb begin
      lane_type            ln;
      logic [QuotWidth-1:0] q;
      rsp_tvalid_in = chain[QuotWidth][0].valid;
      rsp_tuser_in  = chain[QuotWidth][0].degen;
      rsp_tdata_in  = '0;
      for (int k = 0; k < 3; k++) begin
         ln = chain[QuotWidth][k];
         if (ln.degen) begin
            q = '0;
         end else if (ln.neg) begin
            q = (ln.ovf || ln.quot > SatMin) ? SatMin : QuotWidth'(-ln.quot);
         end else begin
            q = (ln.ovf || ln.quot > SatMax) ? SatMax : ln.quot;
         end
         rsp_tdata_in[QuotWidth*k +: QuotWidth] = q;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (en) begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_tdata_ff <= rsp_tdata_in;
         rsp_tuser_ff <= rsp_tuser_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

FILE: tb/triangle_tangent_vector_test.sv
`timescale 1ns / 1ps
module triangle_tangent_vector_test;
   import ttv_pkg::*;

   localparam int Latency    = 36;
   localparam int StallLimit = 5000;

   // One predicted tangent
   typedef struct {
      logic signed [31:0] tx;
      logic signed [31:0] ty;
      logic signed [31:0] tz;
      logic               degen;
   } tangent_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   // vertex_a, vertex_b, vertex_c, uv_a, uv_b, uv_c
   logic [ReqWidth-1:0] req_tdata = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   // tangent_x, tangent_y, tangent_z
   logic [RspWidth-1:0] rsp_tdata;
   // degenerate
   logic                rsp_tuser;

   tangent_type tangent_queue[$];
   int          mismatch_count = 0;
   int          idle_cycles = 0;
   int unsigned cycle_count = 0;

   triangle_tangent_vector u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #2 clock = ~clock;

   // Signed 16-bit lane k of a packed word
   function automatic longint lane16(input logic [47:0] w, input int k);
      logic signed [15:0] s;
      s = w[k*16 +: 16];
      return longint'(s);
   endfunction

   // Divide at full width, truncate toward zero, clamp to Q16.16
   function automatic logic signed [31:0] clamp_quot(input longint num, input longint det);
      longint q;
      q = (num * 64'sd262144) / det;
      if (q > 64'sd2147483647) q = 64'sd2147483647;
      if (q < -64'sd2147483648) q = -64'sd2147483648;
      return q[31:0];
   endfunction

   function automatic tangent_type predict_tangent(
      input logic [47:0] va, input logic [47:0] vb, input logic [47:0] vc,
      input logic [31:0] ua, input logic [31:0] ub, input logic [31:0] uc);
      tangent_type t;
      longint du1, dv1, du2, dv2, det, e1, e2;
      logic signed [31:0] comp[3];
      du1 = lane16(ub, 0) - lane16(ua, 0);
      dv1 = lane16(ub, 1) - lane16(ua, 1);
      du2 = lane16(uc, 0) - lane16(ua, 0);
      dv2 = lane16(uc, 1) - lane16(ua, 1);
      det = du1 * dv2 - du2 * dv1;
      for (int k = 0; k < 3; k++) begin
         e1 = lane16(vb, k) - lane16(va, k);
         e2 = lane16(vc, k) - lane16(va, k);
         comp[k] = (det == 0) ? 32'sd0 : clamp_quot(dv2 * e1 - dv1 * e2, det);
      end
      t.tx    = comp[0];
      t.ty    = comp[1];
      t.tz    = comp[2];
      t.degen = (det == 0);
      return t;
   endfunction

   // Hold one triangle on the bus until taken, then log its prediction
   task automatic send_triangle(
      input logic [47:0] va, input logic [47:0] vb, input logic [47:0] vc,
      input logic [31:0] ua, input logic [31:0] ub, input logic [31:0] uc);
      req_tvalid <= 1'b1;
      req_tdata  <= {uc, ub, ua, vc, vb, va};
      do @(posedge clock); while (!req_tready);
      tangent_queue.insert(tangent_queue.size(), predict_tangent(va, vb, vc, ua, ub, uc));
   endtask

   task automatic pause_sender(input int n);
      req_tvalid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // Hold off until every expected tangent has come back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (tangent_queue.size() != 0);
   endtask

   function automatic logic [47:0] rand_vertex();
      return {16'($urandom), 16'($urandom), 16'($urandom)};
   endfunction

   // Zero determinant: repeated, collinear and all-equal texture coordinates
   task automatic test_degenerate();
      logic [31:0] uv;
      uv = $urandom;
      send_triangle(rand_vertex(), rand_vertex(), rand_vertex(), uv, uv, uv);
      send_triangle(rand_vertex(), rand_vertex(), rand_vertex(), uv, uv, $urandom);
      send_triangle(rand_vertex(), rand_vertex(), rand_vertex(), uv, $urandom, uv);
      send_triangle(48'h7FFF_7FFF_7FFF, 48'h8000_8000_8000, 48'h7FFF_7FFF_7FFF,
                    32'h0000_0000, 32'h0100_0100, 32'h0200_0200);
      send_triangle('0, '0, '0, '0, '0, '0);
      pause_sender(3);
   endtask

   // Extreme components, unit UV frame and saturation in both directions
   task automatic test_extremes();
      send_triangle('0, 48'h1000_1000_1000, 48'h2000_0000_E000,
                    32'h0000_0000, 32'h0000_4000, 32'h4000_0000);
      send_triangle(48'h8000_8000_8000, 48'h7FFF_7FFF_7FFF, 48'h8000_8000_8000,
                    32'h8000_8000, 32'h8000_7FFF, 32'h7FFF_8000);
      send_triangle(48'h7FFF_7FFF_7FFF, 48'h8000_8000_8000, 48'h7FFF_7FFF_7FFF,
                    32'h8000_8000, 32'h7FFF_7FFF, 32'h7FFF_8000);
      // Tiny determinant with large edges saturates
      send_triangle(48'h8000_8000_8000, 48'h7FFF_7FFF_7FFF, 48'h7FFF_8000_7FFF,
                    32'h0000_0000, 32'h0000_0001, 32'h7FFF_0001);
      send_triangle(48'h7FFF_7FFF_7FFF, 48'h8000_8000_8000, 48'h8000_7FFF_8000,
                    32'h0000_0000, 32'h0000_0001, 32'h7FFF_0001);
      send_triangle(48'h7FFF_7FFF_7FFF, 48'h8000_8000_8000, 48'h7FFF_7FFF_7FFF,
                    32'h0000_0000, 32'h8000_0001, 32'h0001_0000);
      send_triangle(48'hFFFF_FFFF_FFFF, '0, 48'h0001_0001_0001,
                    32'hFFFF_FFFF, 32'h7FFF_0000, 32'h0000_7FFF);
      pause_sender(5);
   endtask

   // Random triangles in bursts; some degenerate, some with small UV ranges
   task automatic test_random(input int count);
      logic [31:0] ua, ub, uc;
      int burst;
      burst = $urandom_range(1, 40);
      for (int i = 0; i < count; i++) begin
         ua = $urandom;
         ub = $urandom;
         uc = $urandom;
         case ($urandom_range(0, 9))
            0: uc = ua;
            1: ub = uc;
            2, 3: begin
               ub = {ua[31:16] + 16'($urandom_range(0, 8191)) - 16'd4096,
                     ua[15:0] + 16'($urandom_range(0, 8191)) - 16'd4096};
               uc = {ua[31:16] + 16'($urandom_range(0, 8191)) - 16'd4096,
                     ua[15:0] + 16'($urandom_range(0, 8191)) - 16'd4096};
            end
            default: ;
         endcase
         send_triangle(rand_vertex(), rand_vertex(), rand_vertex(), ua, ub, uc);
         if (--burst == 0) begin
            pause_sender($urandom_range(1, 12));
            burst = $urandom_range(1, 40);
         end
      end
      pause_sender(1);
   endtask

   // Receiver: alternate between always ready, random stalls and a fixed pattern
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      case ((cycle_count >> 9) % 3)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 2) != 0);
         default: rsp_tready <= (cycle_count % 7) > 2;
      endcase
   end

   // Compare each taken tangent with the oldest prediction
   always @(posedge clock) begin
      tangent_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (tangent_queue.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected tangent %h degen %b", rsp_tdata, rsp_tuser);
         end else begin
            want = tangent_queue.pop_front();
            if (rsp_tdata[31:0] !== want.tx || rsp_tdata[63:32] !== want.ty ||
                rsp_tdata[95:64] !== want.tz || rsp_tuser !== want.degen) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("tangent want %h %h %h degen %b, got %h %h %h degen %b",
                           want.tx, want.ty, want.tz, want.degen, rsp_tdata[31:0],
                           rsp_tdata[63:32], rsp_tdata[95:64], rsp_tuser);
            end
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_degenerate();
      test_extremes();
      test_random(900);
      drain_results();
      test_random(900);
      drain_results();
      // Let anything stray fall out before the verdict
      repeat (Latency + 10) @(posedge clock);
      mismatch_count += tangent_queue.size();
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
